@@ sv/dns_question_name_encoder_defines.svh @@
// Assertion macros used by the checker file of the name encoder.
`ifndef DNS_QUESTION_NAME_ENCODER_DEFINES_SVH
`define DNS_QUESTION_NAME_ENCODER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define DQE_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dqe check failed");

// Check a property on every clock edge, reset included.
`define DQE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("dqe check failed");

`endif

@@ sv/dqe_pkg.sv @@
package dqe_pkg;

  // Default limits
  localparam int MAX_LABEL_DEF = 63;
  localparam int MAX_NAME_DEF  = 255;

  // Special characters
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_DOT = 8'h2E;

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] REG_QUERY_TYPE  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_UNICAST     = 2'd1;
  localparam logic [CFG_AW-1:0] REG_QUERY_CLASS = 2'd2;

  localparam logic [14:0] QUERY_TYPE_RST  = 15'd12;
  localparam logic [15:0] QUERY_CLASS_RST = 16'd1;

  // Positions of the question tail: terminator, QTYPE, QCLASS
  localparam logic [2:0] TAIL_ZERO     = 3'd0;
  localparam logic [2:0] TAIL_TYPE_HI  = 3'd1;
  localparam logic [2:0] TAIL_TYPE_LO  = 3'd2;
  localparam logic [2:0] TAIL_CLASS_HI = 3'd3;
  localparam logic [2:0] TAIL_CLASS_LO = 3'd4;

  // Bits of m_tuser
  localparam int TU_PAIR  = 0;
  localparam int TU_ERROR = 1;
  localparam int TU_W     = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LABEL,
    ST_TAIL,
    ST_DRAIN,
    ST_ERR
  } state_t;

endpackage

@@ sv/dns_question_name_encoder.sv @@
// Channel   Dir  Width  Contents
// s_axis    in   8      tdata: char_code[7:0]
// m_axis    out  16+2   tdata: first_byte, second_byte; tuser: pair_valid, error;
//                       tlast: last
// cfg       in   2+16   cfg_addr selects query_type, unicast_response, query_class
//
// An ordinary character gives no word.
// A dot sends its label (L label characters): one wire byte a cycle leaves
// the label memory read port unless m_tready stalls the byte pipeline;
// two bytes make one word. A NUL adds five tail bytes.
// An error word is loaded once the output register is free.
// s_tready is high only while the sequencer is idle; a finished word may still
// wait in the output register. m_tready low stalls the byte pipeline in place.
// rst is synchronous and active high; no memory clearing pass.
module dns_question_name_encoder #(
  parameter int MAX_LABEL = dqe_pkg::MAX_LABEL_DEF,
  parameter int MAX_NAME  = dqe_pkg::MAX_NAME_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // char_code[7:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,   // first_byte[7:0], second_byte[15:8]
  output logic [dqe_pkg::TU_W-1:0]   m_tuser,   // pair_valid[0], error[1]
  output logic                       m_tlast,
  input  logic                       cfg_we,
  input  logic [dqe_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [dqe_pkg::CFG_DW-1:0] cfg_data
);

  localparam int LBL_AW = $clog2(MAX_LABEL + 1);
  localparam int NAME_W = $clog2(MAX_NAME + 1);
  localparam int SUM_W  = ((NAME_W > LBL_AW) ? NAME_W : LBL_AW) + 2;
  localparam int IDX_W  = (LBL_AW > 3) ? LBL_AW : 3;
  localparam int DEPTH  = 2 ** LBL_AW;

  dqe_pkg::state_t state, state_next;

  // Configuration registers
  logic [14:0] query_type;
  logic        unicast_response;
  logic [15:0] query_class;

  // Name tracking
  logic [LBL_AW-1:0] label_count;
  logic [NAME_W-1:0] name_count;
  logic              discarding;
  logic              final_q;

  // Byte sequencer and label memory
  logic [7:0]        label_mem [DEPTH];
  logic [IDX_W-1:0]  idx;
  logic [7:0]        rdata;
  logic              a_go, a_end, a_from_mem, a_last;
  logic [7:0]        a_const;
  logic [LBL_AW-1:0] raddr;

  // Byte stage and pair packer
  logic       b_valid, b_from_mem, b_last, b_adv, b_needs_out;
  logic [7:0] b_const, b_byte;
  logic       h_valid;
  logic [7:0] h_byte;
  logic       out_free, emit, err_load;

  // Input decode
  logic              s_acc, is_nul, is_dot, label_full, name_fits;
  logic              go_err, go_label, go_tail, store_char;
  logic [SUM_W-1:0]  need_len;

  assign s_acc      = s_tvalid && s_tready;
  assign is_nul     = (s_tdata == dqe_pkg::CHAR_NUL);
  assign is_dot     = (s_tdata == dqe_pkg::CHAR_DOT);
  assign label_full = (label_count >= LBL_AW'(MAX_LABEL));
  assign need_len   = SUM_W'(name_count) + SUM_W'(label_count) + SUM_W'(2);
  assign name_fits  = (need_len <= SUM_W'(MAX_NAME));

  assign go_err = s_acc && !discarding &&
                  ((is_nul && (label_count != '0) && !name_fits) ||
                   (is_dot && ((label_count == '0) || !name_fits)) ||
                   (!is_nul && !is_dot && label_full));
  assign go_label   = s_acc && !discarding && (is_nul || is_dot) &&
                      (label_count != '0) && name_fits;
  assign go_tail    = s_acc && !discarding && is_nul && (label_count == '0);
  assign store_char = s_acc && !discarding && !is_nul && !is_dot && !label_full;

  // Byte stage advance and packing
  assign out_free    = !m_tvalid || m_tready;
  assign b_needs_out = h_valid || b_last;
  assign b_adv       = b_valid && (!b_needs_out || out_free);
  assign emit        = b_adv && b_needs_out;
  assign b_byte      = b_from_mem ? rdata : b_const;

  // Mark the last byte of the label or tail stream
  assign a_end = ((state == dqe_pkg::ST_LABEL) && (idx == IDX_W'(label_count))) ||
                 ((state == dqe_pkg::ST_TAIL) && (idx[2:0] == dqe_pkg::TAIL_CLASS_LO));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dqe_pkg::ST_IDLE: begin
        if (go_err) state_next = dqe_pkg::ST_ERR;
        else if (go_label) state_next = dqe_pkg::ST_LABEL;
        else if (go_tail) state_next = dqe_pkg::ST_TAIL;
      end
      dqe_pkg::ST_LABEL: begin
        if (a_go && a_end) state_next = final_q ? dqe_pkg::ST_TAIL : dqe_pkg::ST_DRAIN;
      end
      dqe_pkg::ST_TAIL: begin
        if (a_go && a_end) state_next = dqe_pkg::ST_DRAIN;
      end
      dqe_pkg::ST_DRAIN: begin
        if (!b_valid || b_adv) state_next = dqe_pkg::ST_IDLE;
      end
      dqe_pkg::ST_ERR: begin
        if (out_free) state_next = dqe_pkg::ST_IDLE;
      end
      default: state_next = dqe_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready = 1'b0;
    a_go     = 1'b0;
    err_load = 1'b0;
    unique case (state)
      dqe_pkg::ST_IDLE:  s_tready = 1'b1;
      dqe_pkg::ST_LABEL: a_go = !b_valid || b_adv;
      dqe_pkg::ST_TAIL:  a_go = !b_valid || b_adv;
      dqe_pkg::ST_DRAIN: a_go = 1'b0;
      dqe_pkg::ST_ERR:   err_load = out_free;
      default:           s_tready = 1'b0;
    endcase
  end

  // Select the byte the sequencer issues
  always_comb begin
    a_from_mem = 1'b0;
    a_const    = 8'(label_count);
    a_last     = 1'b0;
    raddr      = LBL_AW'(idx - IDX_W'(1));
    if (state == dqe_pkg::ST_LABEL) begin
      a_from_mem = (idx != '0);
      a_last     = a_end && !final_q;
    end else begin
      a_last = a_end;
      case (idx[2:0])
        dqe_pkg::TAIL_ZERO:     a_const = 8'h00;
        dqe_pkg::TAIL_TYPE_HI:  a_const = {unicast_response, query_type[14:8]};
        dqe_pkg::TAIL_TYPE_LO:  a_const = query_type[7:0];
        dqe_pkg::TAIL_CLASS_HI: a_const = query_class[15:8];
        dqe_pkg::TAIL_CLASS_LO: a_const = query_class[7:0];
        default:                a_const = 8'h00;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= dqe_pkg::ST_IDLE;
      query_type       <= dqe_pkg::QUERY_TYPE_RST;
      unicast_response <= 1'b0;
      query_class      <= dqe_pkg::QUERY_CLASS_RST;
      label_count      <= '0;
      name_count       <= '0;
      discarding       <= 1'b0;
      final_q          <= 1'b0;
      idx              <= '0;
      b_valid          <= 1'b0;
      h_valid          <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      state <= state_next;

      // Write configuration
      if (cfg_we) begin
        unique case (cfg_addr)
          dqe_pkg::REG_QUERY_TYPE:  query_type       <= cfg_data[14:0];
          dqe_pkg::REG_UNICAST:     unicast_response <= cfg_data[0];
          dqe_pkg::REG_QUERY_CLASS: query_class      <= cfg_data;
          default: ;
        endcase
      end

      // Track the name on accepted characters
      if (s_acc) final_q <= is_nul;
      if (s_acc && discarding && is_nul) discarding <= 1'b0;
      if (go_err) begin
        label_count <= '0;
        name_count  <= '0;
        discarding  <= !is_nul;
      end
      if (store_char) label_count <= label_count + LBL_AW'(1);
      if (go_label && is_dot) name_count <= NAME_W'(need_len - SUM_W'(1));
      if ((go_label && is_nul) || go_tail) name_count <= '0;
      if (go_label || go_tail) idx <= '0;

      // Advance the sequencer
      if (a_go) begin
        idx <= a_end ? '0 : idx + IDX_W'(1);
        if (a_end && (state == dqe_pkg::ST_LABEL)) label_count <= '0;
      end

      // Byte stage and packer occupancy
      if (a_go) b_valid <= 1'b1;
      else if (b_adv) b_valid <= 1'b0;
      if (b_adv) h_valid <= !h_valid && !b_last;

      // Output register
      if (emit || err_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (a_go) begin
      b_from_mem <= a_from_mem;
      b_const    <= a_const;
      b_last     <= a_last;
    end
    if (b_adv && !h_valid) h_byte <= b_byte;
    if (emit) begin
      m_tdata                    <= h_valid ? {b_byte, h_byte} : {8'h00, b_byte};
      m_tuser[dqe_pkg::TU_PAIR]  <= h_valid;
      m_tuser[dqe_pkg::TU_ERROR] <= 1'b0;
      m_tlast                    <= b_last && final_q;
    end else if (err_load) begin
      m_tdata                    <= 16'h0000;
      m_tuser[dqe_pkg::TU_PAIR]  <= 1'b0;
      m_tuser[dqe_pkg::TU_ERROR] <= 1'b1;
      m_tlast                    <= 1'b1;
    end
  end

  // Label memory: write on stored characters, registered read
  always_ff @(posedge clk) begin
    if (store_char) label_mem[label_count] <= s_tdata;
    if (a_go && a_from_mem) rdata <= label_mem[raddr];
  end

endmodule

@@ sv/dqe_checker.sv @@
`include "dns_question_name_encoder_defines.svh"

module dqe_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [15:0]              m_tdata,
  input logic [dqe_pkg::TU_W-1:0] m_tuser,
  input logic                     m_tlast
);

  // Hold a stalled word
  `DQE_ASSERT(a_stall_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // Error word is a single zero byte closing the question
  `DQE_ASSERT(a_err_shape, clk, rst, m_tvalid && m_tuser[dqe_pkg::TU_ERROR] |-> m_tlast && !m_tuser[dqe_pkg::TU_PAIR] && (m_tdata == 16'h0000))

  // A pair word never flags an error
  `DQE_ASSERT(a_pair_ok, clk, rst, m_tvalid && m_tuser[dqe_pkg::TU_PAIR] |-> !m_tuser[dqe_pkg::TU_ERROR])

  // Come out of reset idle and empty
  `DQE_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> s_tready && !m_tvalid)

endmodule

bind dns_question_name_encoder dqe_checker u_dqe_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
